>>> design/bts_pkg.sv
// shared types and constants for the ber tlv stream parser
package bts_pkg;

  localparam int unsigned MAX_DEPTH_DEF = 4;
  localparam int unsigned MAX_ITEMS_DEF = 15;
  localparam int unsigned MAX_RES       = 3;
  localparam int unsigned FIFO_DEPTH    = 4;

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN1 = 2'd1,
    PH_LENL = 2'd2,
    PH_BODY = 2'd3
  } bts_phase_e;

  typedef enum logic [2:0] {
    TK_HEADER  = 3'd0,
    TK_INT     = 3'd1,
    TK_OCT     = 3'd2,
    TK_ARC     = 3'd3,
    TK_UNKNOWN = 3'd4,
    TK_TRUNC   = 3'd5,
    TK_DEEP    = 3'd6
  } bts_kind_e;

  typedef enum logic [2:0] {
    TY_INT  = 3'd0,
    TY_OCT  = 3'd1,
    TY_NULL = 3'd2,
    TY_OID  = 3'd3,
    TY_SEQ  = 3'd4,
    TY_PDU  = 3'd5
  } bts_type_e;

  typedef enum logic [2:0] {
    REG_INTEGER  = 3'd0,
    REG_OCTETS   = 3'd1,
    REG_NULL     = 3'd2,
    REG_OID      = 3'd3,
    REG_SEQUENCE = 3'd4,
    REG_PDU      = 3'd5
  } bts_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } bts_in_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [2:0]  item_type;
    logic [63:0] token_value;
    logic [2:0]  nest_level;
    logic        last_of_run;
  } bts_res_t;

endpackage

>>> design/bts_res_fifo.sv
// result queue: takes up to three results per cycle, hands out one per cycle while the reader is ready
module bts_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_n_i,
  input  bts_pkg::bts_res_t   push_data_i [bts_pkg::MAX_RES],
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bts_pkg::bts_res_t   out_data_o
);

  localparam int unsigned PW = $clog2(bts_pkg::FIFO_DEPTH);
  localparam int unsigned CW = $clog2(bts_pkg::FIFO_DEPTH + 1);

  bts_pkg::bts_res_t mem_q [bts_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign pop         = (cnt_q != '0) && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  // room for a full burst of results
  assign room_o      = (cnt_q <= CW'(bts_pkg::FIFO_DEPTH - bts_pkg::MAX_RES));

  always_comb begin
    wr_d  = wr_q + PW'(push_n_i);
    rd_d  = rd_q + PW'(pop);
    cnt_d = cnt_q + CW'(push_n_i) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < int'(bts_pkg::MAX_RES); k++) begin
      if (k < int'(push_n_i)) begin
        mem_q[wr_q + PW'(k)] <= push_data_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> design/ber_tlv_stream_parser.sv
// ber tlv stream parser: one message byte per item, up to three results per byte
// results of a byte are in the result queue in the cycle after it is taken
// throughput: one byte per cycle while each byte yields at most one result and the reader is ready;
//   a byte is taken only when the four-entry result queue has room for three
// reset: all parse state cleared, tag registers back to their defaults;
//   after a byte marked last the parse state clears again, tag registers kept
module ber_tlv_stream_parser #(
  parameter int unsigned MaxDepth = bts_pkg::MAX_DEPTH_DEF,
  parameter int unsigned MaxItems = bts_pkg::MAX_ITEMS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bts_pkg::bts_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bts_pkg::bts_res_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i
);

  localparam int unsigned LW = $clog2(MaxDepth + 1);           // level width
  localparam int unsigned RW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
  localparam int unsigned CW = $clog2(MaxItems + 1);           // item count width

  // tag registers
  logic [7:0] tag_q [6];

  // parse state
  bts_pkg::bts_phase_e phase_q, phase_d;
  bts_pkg::bts_type_e  ctype_q, ctype_d;
  logic [31:0] lacc_q, lacc_d;           // length being read
  logic [6:0]  lleft_q, lleft_d;         // long-form length bytes still due
  logic [31:0] cleft_q, cleft_d;         // content bytes left in this item
  logic [63:0] vacc_q, vacc_d;           // integer or oid arc accumulator
  logic        first_q, first_d;         // next body byte is the first
  logic [31:0] rem_q [MaxDepth];         // bytes left in each open level
  logic [31:0] rem_d [MaxDepth];
  logic [CW-1:0] cnt_q [MaxDepth+1];     // items seen on each level
  logic [CW-1:0] cnt_d [MaxDepth+1];
  logic        skip_q [MaxDepth+1];      // rest of level ignored
  logic        skip_d [MaxDepth+1];
  logic [LW-1:0] lvl_q, lvl_d;

  bts_pkg::bts_res_t res [bts_pkg::MAX_RES];
  logic [1:0]        res_n;
  logic              room;
  logic              acc;

  assign acc         = in_valid_i && in_ready_o;
  assign in_ready_o  = room;
  assign cfg_ready_o = 1'b1;

  function automatic bts_pkg::bts_res_t mk_res(bts_pkg::bts_kind_e k, bts_pkg::bts_type_e t,
                                               logic [63:0] v, logic [LW-1:0] l);
    bts_pkg::bts_res_t r;
    r.token_kind  = k;
    r.item_type   = t;
    r.token_value = v;
    r.nest_level  = 3'(l);
    r.last_of_run = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [7:0]         b;
    logic               at_end;
    logic               fin;
    logic               known;
    logic [RW-1:0]      ri;
    logic [31:0]        len;
    logic [7:0]         arc1;
    logic [1:0]         arc0;
    logic [63:0]        va_n;
    bts_pkg::bts_type_e t;

    b       = in_data_i.data_byte;
    phase_d = phase_q;
    ctype_d = ctype_q;
    lacc_d  = lacc_q;
    lleft_d = lleft_q;
    cleft_d = cleft_q;
    vacc_d  = vacc_q;
    first_d = first_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    skip_d  = skip_q;
    lvl_d   = lvl_q;
    res_n   = '0;
    for (int k = 0; k < int'(bts_pkg::MAX_RES); k++) begin
      res[k] = '0;
    end
    at_end = 1'b0;
    fin    = 1'b0;
    known  = 1'b1;
    len    = '0;
    arc0   = '0;
    arc1   = '0;
    va_n   = '0;
    t      = bts_pkg::TY_INT;
    ri     = RW'(lvl_q - LW'(1));

    // the enclosing level loses one byte
    if (lvl_q != '0) begin
      if (rem_d[ri] != '0) rem_d[ri] = rem_d[ri] - 32'd1;
      at_end = (rem_d[ri] == '0);
    end

    if (!skip_q[lvl_q]) begin
      case (phase_q)
        bts_pkg::PH_TAG: begin
          if (cnt_q[lvl_q] >= CW'(MaxItems)) begin
            skip_d[lvl_q] = 1'b1;
          end else begin
            cnt_d[lvl_q] = cnt_q[lvl_q] + CW'(1);
            // equal tags resolve in register order
            if (b == tag_q[bts_pkg::REG_INTEGER])       t = bts_pkg::TY_INT;
            else if (b == tag_q[bts_pkg::REG_OCTETS])   t = bts_pkg::TY_OCT;
            else if (b == tag_q[bts_pkg::REG_NULL])     t = bts_pkg::TY_NULL;
            else if (b == tag_q[bts_pkg::REG_OID])      t = bts_pkg::TY_OID;
            else if (b == tag_q[bts_pkg::REG_SEQUENCE]) t = bts_pkg::TY_SEQ;
            else if (b == tag_q[bts_pkg::REG_PDU])      t = bts_pkg::TY_PDU;
            else known = 1'b0;
            if (!known) begin
              res[res_n] = mk_res(bts_pkg::TK_UNKNOWN, bts_pkg::TY_INT, 64'(b), lvl_q);
              res_n = res_n + 2'd1;
              skip_d[lvl_q] = 1'b1;
            end else if ((t == bts_pkg::TY_SEQ || t == bts_pkg::TY_PDU) &&
                         (lvl_q >= LW'(MaxDepth))) begin
              res[res_n] = mk_res(bts_pkg::TK_DEEP, t, 64'(b), lvl_q);
              res_n = res_n + 2'd1;
              skip_d[lvl_q] = 1'b1;
            end else begin
              ctype_d = t;
              lacc_d  = '0;
              phase_d = bts_pkg::PH_LEN1;
            end
          end
        end
        bts_pkg::PH_LEN1: begin
          if (b[7]) begin
            lleft_d = b[6:0];
            // indefinite form reads as length zero
            if (b[6:0] == '0) fin = 1'b1;
            else phase_d = bts_pkg::PH_LENL;
          end else begin
            lacc_d = 32'(b);
            fin    = 1'b1;
          end
        end
        bts_pkg::PH_LENL: begin
          lacc_d = {lacc_q[23:0], b};
          if (lleft_q != '0) lleft_d = lleft_q - 7'd1;
          if (lleft_d == '0) fin = 1'b1;
        end
        default: begin
          case (ctype_q)
            bts_pkg::TY_INT: begin
              if (lacc_q <= 32'd8) vacc_d = {vacc_q[55:0], b};
            end
            bts_pkg::TY_OCT: begin
              res[res_n] = mk_res(bts_pkg::TK_OCT, bts_pkg::TY_OCT, 64'(b), lvl_q);
              res_n = res_n + 2'd1;
            end
            bts_pkg::TY_OID: begin
              if (first_q) begin
                // first byte carries two arcs
                if (b < 8'd40)      begin arc0 = 2'd0; arc1 = b; end
                else if (b < 8'd80) begin arc0 = 2'd1; arc1 = b - 8'd40; end
                else                begin arc0 = 2'd2; arc1 = b - 8'd80; end
                res[0] = mk_res(bts_pkg::TK_ARC, bts_pkg::TY_OID, 64'(arc0), lvl_q);
                res[1] = mk_res(bts_pkg::TK_ARC, bts_pkg::TY_OID, 64'(arc1), lvl_q);
                res_n = 2'd2;
                first_d = 1'b0;
              end else begin
                va_n = {vacc_q[56:0], b[6:0]};
                vacc_d = va_n;
                if (!b[7]) begin
                  res[res_n] = mk_res(bts_pkg::TK_ARC, bts_pkg::TY_OID, va_n, lvl_q);
                  res_n = res_n + 2'd1;
                  vacc_d = '0;
                end
              end
            end
            default: ;
          endcase
          if (cleft_q != '0) cleft_d = cleft_q - 32'd1;
          if (cleft_d == '0) begin
            if (ctype_q == bts_pkg::TY_INT && res_n < 2'd3) begin
              res[res_n] = mk_res(bts_pkg::TK_INT, bts_pkg::TY_INT, vacc_d, lvl_q);
              res_n = res_n + 2'd1;
            end
            phase_d = bts_pkg::PH_TAG;
          end
        end
      endcase

      // level ran out inside a header
      if (at_end && (phase_d == bts_pkg::PH_LEN1 || phase_d == bts_pkg::PH_LENL)) fin = 1'b1;

      if (fin) begin
        len = lacc_d;
        if (lvl_q != '0 && len > rem_d[ri]) len = rem_d[ri];
        res[res_n] = mk_res(bts_pkg::TK_HEADER, ctype_d, 64'(len), lvl_q);
        res_n   = res_n + 2'd1;
        phase_d = bts_pkg::PH_TAG;
        cleft_d = len;
        vacc_d  = '0;
        first_d = 1'b1;
        if (ctype_d == bts_pkg::TY_SEQ || ctype_d == bts_pkg::TY_PDU) begin
          // open a child level
          if (len != '0 && lvl_q < LW'(MaxDepth)) begin
            if (lvl_q != '0) rem_d[ri] = rem_d[ri] - len;
            rem_d[RW'(lvl_q)]        = len;
            lvl_d                    = lvl_q + LW'(1);
            cnt_d[lvl_q + LW'(1)]    = '0;
            skip_d[lvl_q + LW'(1)]   = 1'b0;
          end
        end else if (len == '0) begin
          if (ctype_d == bts_pkg::TY_INT) begin
            res[res_n] = mk_res(bts_pkg::TK_INT, bts_pkg::TY_INT, 64'd0, lvl_q);
            res_n = res_n + 2'd1;
          end
        end else begin
          phase_d = bts_pkg::PH_BODY;
        end
      end
    end

    // close every exhausted level
    for (int i = 0; i < int'(MaxDepth); i++) begin
      if (lvl_d != '0 && rem_d[RW'(lvl_d - LW'(1))] == '0) begin
        lvl_d   = lvl_d - LW'(1);
        phase_d = bts_pkg::PH_TAG;
      end
    end

    if (in_data_i.last_byte) begin
      if ((phase_d != bts_pkg::PH_TAG || lvl_d != '0) && res_n < 2'd3) begin
        res[res_n] = mk_res(bts_pkg::TK_TRUNC, bts_pkg::TY_INT, 64'd0, lvl_d);
        res_n = res_n + 2'd1;
      end
      phase_d = bts_pkg::PH_TAG;
      ctype_d = bts_pkg::TY_INT;
      lacc_d  = '0;
      lleft_d = '0;
      cleft_d = '0;
      vacc_d  = '0;
      first_d = 1'b0;
      lvl_d   = '0;
      for (int i = 0; i < int'(MaxDepth); i++) rem_d[i] = '0;
      for (int i = 0; i <= int'(MaxDepth); i++) begin
        cnt_d[i]  = '0;
        skip_d[i] = 1'b0;
      end
    end

    if (res_n != '0) res[res_n - 2'd1].last_of_run = 1'b1;
    if (!acc) res_n = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[bts_pkg::REG_INTEGER]  <= 8'd2;
      tag_q[bts_pkg::REG_OCTETS]   <= 8'd4;
      tag_q[bts_pkg::REG_NULL]     <= 8'd5;
      tag_q[bts_pkg::REG_OID]      <= 8'd6;
      tag_q[bts_pkg::REG_SEQUENCE] <= 8'd48;
      tag_q[bts_pkg::REG_PDU]      <= 8'd160;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bts_pkg::REG_INTEGER:  tag_q[bts_pkg::REG_INTEGER]  <= cfg_data_i;
        bts_pkg::REG_OCTETS:   tag_q[bts_pkg::REG_OCTETS]   <= cfg_data_i;
        bts_pkg::REG_NULL:     tag_q[bts_pkg::REG_NULL]     <= cfg_data_i;
        bts_pkg::REG_OID:      tag_q[bts_pkg::REG_OID]      <= cfg_data_i;
        bts_pkg::REG_SEQUENCE: tag_q[bts_pkg::REG_SEQUENCE] <= cfg_data_i;
        bts_pkg::REG_PDU:      tag_q[bts_pkg::REG_PDU]      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bts_pkg::PH_TAG;
      ctype_q <= bts_pkg::TY_INT;
      lacc_q  <= '0;
      lleft_q <= '0;
      cleft_q <= '0;
      vacc_q  <= '0;
      first_q <= 1'b0;
      lvl_q   <= '0;
      for (int i = 0; i < int'(MaxDepth); i++) rem_q[i] <= '0;
      for (int i = 0; i <= int'(MaxDepth); i++) begin
        cnt_q[i]  <= '0;
        skip_q[i] <= 1'b0;
      end
    end else if (acc) begin
      phase_q <= phase_d;
      ctype_q <= ctype_d;
      lacc_q  <= lacc_d;
      lleft_q <= lleft_d;
      cleft_q <= cleft_d;
      vacc_q  <= vacc_d;
      first_q <= first_d;
      lvl_q   <= lvl_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      skip_q  <= skip_d;
    end
  end

  bts_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (res_n),
    .push_data_i (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> test/ber_tlv_stream_parser_tb.sv
// testbench for the ber tlv stream parser: table-driven and random messages checked against a predictor
`timescale 1ns / 100ps
module ber_tlv_stream_parser_tb;

  typedef logic [7:0] byte_q_t[$];

  // one row of the directed table; tok is typed in only where typed is set
  typedef struct {
    logic [7:0]        b;
    bit                last;
    bit                typed;
    bts_pkg::bts_res_t tok;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  bts_pkg::bts_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  bts_pkg::bts_res_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [7:0]        cfg_data = '0;

  ber_tlv_stream_parser dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #10 clk = ~clk;

  // tokens still owed by the block, oldest first
  bts_pkg::bts_res_t pending_tokens[$];
  int       n_fail = 0;
  bit       idle_on = 1'b1;

  // predictor copy of the tag registers and the parse state
  logic [7:0]           tag_reg[6];
  bts_pkg::bts_phase_e  ph;
  bts_pkg::bts_type_e   cur_ty;
  logic [31:0] len_acc, body_left;
  logic [6:0]  len_bytes_left;
  logic [63:0] val_acc;
  bit          first_body;
  int unsigned lvl;
  logic [31:0] lvl_rem[bts_pkg::MAX_DEPTH_DEF];
  int unsigned lvl_cnt[bts_pkg::MAX_DEPTH_DEF+1];
  bit          lvl_skip[bts_pkg::MAX_DEPTH_DEF+1];
  bts_pkg::bts_res_t step_toks[$];

  function automatic void push_tok(bts_pkg::bts_kind_e k, bts_pkg::bts_type_e t,
                                   logic [63:0] v);
    // the block keeps at most three tokens per byte
    if (step_toks.size() < bts_pkg::MAX_RES)
      step_toks.push_back('{token_kind: k, item_type: t, token_value: v,
                            nest_level: lvl[2:0], last_of_run: 1'b0});
  endfunction

  function automatic void clear_parse();
    ph = bts_pkg::PH_TAG;
    cur_ty = bts_pkg::TY_INT;
    len_acc = '0;
    len_bytes_left = '0;
    body_left = '0;
    val_acc = '0;
    first_body = 1'b0;
    lvl = 0;
    for (int i = 0; i < bts_pkg::MAX_DEPTH_DEF; i++) lvl_rem[i] = '0;
    for (int i = 0; i <= bts_pkg::MAX_DEPTH_DEF; i++) begin
      lvl_cnt[i] = 0;
      lvl_skip[i] = 1'b0;
    end
  endfunction

  // header done: clamp length to the parent's remaining bytes, maybe open a level
  function automatic void close_header();
    logic [31:0] n;
    int unsigned lv;
    n = len_acc;
    lv = lvl;
    if (lv > 0 && n > lvl_rem[lv-1]) n = lvl_rem[lv-1];
    push_tok(bts_pkg::TK_HEADER, cur_ty, {32'b0, n});
    ph = bts_pkg::PH_TAG;
    body_left = n;
    val_acc = '0;
    first_body = 1'b1;
    if (cur_ty == bts_pkg::TY_SEQ || cur_ty == bts_pkg::TY_PDU) begin
      if (n > 0 && lv < bts_pkg::MAX_DEPTH_DEF) begin
        if (lv > 0) lvl_rem[lv-1] -= n;
        lvl_rem[lv] = n;
        lvl = lv + 1;
        lvl_cnt[lv+1] = 0;
        lvl_skip[lv+1] = 1'b0;
      end
      return;
    end
    if (n == 0) begin
      if (cur_ty == bts_pkg::TY_INT) push_tok(bts_pkg::TK_INT, bts_pkg::TY_INT, '0);
      return;
    end
    ph = bts_pkg::PH_BODY;
  endfunction

  function automatic void take_tag(logic [7:0] b);
    int unsigned lv;
    bts_pkg::bts_type_e t;
    lv = lvl;
    // too many items on this level: drop silently and skip the rest
    if (lvl_cnt[lv] >= bts_pkg::MAX_ITEMS_DEF) begin
      lvl_skip[lv] = 1'b1;
      return;
    end
    lvl_cnt[lv]++;
    if (b == tag_reg[bts_pkg::REG_INTEGER]) t = bts_pkg::TY_INT;
    else if (b == tag_reg[bts_pkg::REG_OCTETS]) t = bts_pkg::TY_OCT;
    else if (b == tag_reg[bts_pkg::REG_NULL]) t = bts_pkg::TY_NULL;
    else if (b == tag_reg[bts_pkg::REG_OID]) t = bts_pkg::TY_OID;
    else if (b == tag_reg[bts_pkg::REG_SEQUENCE]) t = bts_pkg::TY_SEQ;
    else if (b == tag_reg[bts_pkg::REG_PDU]) t = bts_pkg::TY_PDU;
    else begin
      push_tok(bts_pkg::TK_UNKNOWN, bts_pkg::TY_INT, {56'b0, b});
      lvl_skip[lv] = 1'b1;
      return;
    end
    if ((t == bts_pkg::TY_SEQ || t == bts_pkg::TY_PDU) && lv >= bts_pkg::MAX_DEPTH_DEF) begin
      push_tok(bts_pkg::TK_DEEP, t, {56'b0, b});
      lvl_skip[lv] = 1'b1;
      return;
    end
    cur_ty = t;
    len_acc = '0;
    ph = bts_pkg::PH_LEN1;
  endfunction

  function automatic void take_body(logic [7:0] b);
    logic [1:0] arc0;
    if (cur_ty == bts_pkg::TY_INT) begin
      // over-long integers stop accumulating and report zero
      if (len_acc <= 8) val_acc = (val_acc << 8) | {56'b0, b};
    end else if (cur_ty == bts_pkg::TY_OCT) begin
      push_tok(bts_pkg::TK_OCT, bts_pkg::TY_OCT, {56'b0, b});
    end else if (cur_ty == bts_pkg::TY_OID) begin
      if (first_body) begin
        // first byte splits into two arcs, top arc capped at 2
        arc0 = (b < 40) ? 2'd0 : ((b < 80) ? 2'd1 : 2'd2);
        push_tok(bts_pkg::TK_ARC, bts_pkg::TY_OID, {62'b0, arc0});
        push_tok(bts_pkg::TK_ARC, bts_pkg::TY_OID, {56'b0, b - 8'(40 * arc0)});
        first_body = 1'b0;
      end else begin
        val_acc = (val_acc << 7) + {57'b0, b[6:0]};
        if (!b[7]) begin
          push_tok(bts_pkg::TK_ARC, bts_pkg::TY_OID, val_acc);
          val_acc = '0;
        end
      end
    end
    if (body_left > 0) body_left--;
    if (body_left == 0) begin
      if (cur_ty == bts_pkg::TY_INT) push_tok(bts_pkg::TK_INT, bts_pkg::TY_INT, val_acc);
      ph = bts_pkg::PH_TAG;
    end
  endfunction

  // advance the predictor by one byte; tokens land in step_toks
  function automatic void predict_tokens(logic [7:0] b, bit last);
    int unsigned lv;
    bit at_end;
    step_toks.delete();
    lv = lvl;
    at_end = 1'b0;
    if (lv > 0) begin
      if (lvl_rem[lv-1] > 0) lvl_rem[lv-1]--;
      at_end = (lvl_rem[lv-1] == 0);
    end
    if (!lvl_skip[lv]) begin
      case (ph)
        bts_pkg::PH_TAG: take_tag(b);
        bts_pkg::PH_LEN1: begin
          if (b[7]) begin
            len_bytes_left = b[6:0];
            // indefinite length reads as zero
            if (len_bytes_left == 0) close_header();
            else ph = bts_pkg::PH_LENL;
          end else begin
            len_acc = {24'b0, b};
            close_header();
          end
        end
        bts_pkg::PH_LENL: begin
          len_acc = (len_acc << 8) | {24'b0, b};
          if (len_bytes_left > 0) len_bytes_left--;
          if (len_bytes_left == 0) close_header();
        end
        default: take_body(b);
      endcase
      // parent ran out in the middle of a header
      if (at_end && (ph == bts_pkg::PH_LEN1 || ph == bts_pkg::PH_LENL)) close_header();
    end
    while (lvl > 0 && lvl_rem[lvl-1] == 0) begin
      lvl--;
      ph = bts_pkg::PH_TAG;
    end
    if (last) begin
      if (ph != bts_pkg::PH_TAG || lvl > 0)
        push_tok(bts_pkg::TK_TRUNC, bts_pkg::TY_INT, '0);
      clear_parse();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_of_run = 1'b1;
  endfunction

  // token sink with random stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (idle_on && stall_left > 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 19);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare every taken token with the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        $error("token with none owed: kind %0d value %0h", out_data.token_kind,
               out_data.token_value);
        n_fail++;
      end else begin
        bts_pkg::bts_res_t w;
        w = pending_tokens.pop_front();
        if (out_data.token_kind !== w.token_kind) begin
          $error("token_kind exp %0d got %0d", w.token_kind, out_data.token_kind);
          n_fail++;
        end
        if (out_data.item_type !== w.item_type) begin
          $error("item_type exp %0d got %0d", w.item_type, out_data.item_type);
          n_fail++;
        end
        if (out_data.token_value !== w.token_value) begin
          $error("token_value exp %0h got %0h", w.token_value, out_data.token_value);
          n_fail++;
        end
        if (out_data.nest_level !== w.nest_level) begin
          $error("nest_level exp %0d got %0d", w.nest_level, out_data.nest_level);
          n_fail++;
        end
        if (out_data.last_of_run !== w.last_of_run) begin
          $error("last_of_run exp %0b got %0b", w.last_of_run, out_data.last_of_run);
          n_fail++;
        end
      end
    end
  end

  // watchdog: too long without any handshake
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == 3000) begin
      $display("ber_tlv_stream_parser_tb: errors");
      $finish;
    end
  end

  // send one byte; valid stays high on return, so back-to-back items drop it only for a random idle gap
  task automatic put_byte(logic [7:0] b, bit last, bit typed, bts_pkg::bts_res_t tok);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (!in_ready);
    predict_tokens(b, last);
    if (typed) pending_tokens.push_back(tok);
    else foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
  endtask

  task automatic send_msg(byte_q_t q);
    foreach (q[i]) put_byte(q[i], i == q.size() - 1, 1'b0, '0);
  endtask

  // sender pause: all owed tokens out, then the block's latency
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tags(logic [7:0] v0, logic [7:0] v1, logic [7:0] v2,
                            logic [7:0] v3, logic [7:0] v4, logic [7:0] v5);
    logic [7:0] v[6];
    v = '{v0, v1, v2, v3, v4, v5};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= v[i];
      do @(posedge clk); while (!cfg_ready);
      tag_reg[i] = v[i];
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one random item, recursing into constructed ones
  function automatic void gen_item(int depth, ref byte_q_t q);
    byte_q_t body;
    int k, n, nk;
    logic [7:0] tag;
    k = $urandom_range(0, 19);
    if (depth >= 5 && k >= 11 && k <= 16) k = 0;
    if (k <= 3) begin
      tag = tag_reg[bts_pkg::REG_INTEGER];
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 10) : $urandom_range(0, 8);
      repeat (n) body.push_back(8'($urandom));
    end else if (k <= 6) begin
      tag = tag_reg[bts_pkg::REG_OCTETS];
      repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
    end else if (k == 7) begin
      tag = tag_reg[bts_pkg::REG_NULL];
      repeat ($urandom_range(0, 1)) body.push_back(8'($urandom));
    end else if (k <= 10) begin
      tag = tag_reg[bts_pkg::REG_OID];
      repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
    end else if (k <= 16) begin
      tag = (k <= 13) ? tag_reg[bts_pkg::REG_SEQUENCE] : tag_reg[bts_pkg::REG_PDU];
      // now and then one child too many for a level
      nk = ($urandom_range(0, 15) == 0) ? 16 : $urandom_range(1, 3);
      repeat (nk) gen_item(depth + 1, body);
    end else begin
      tag = 8'($urandom);
      repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
    end
    q.push_back(tag);
    n = body.size();
    case ($urandom_range(0, 29))
      0: q.push_back(8'h80);
      1: begin
        q.push_back(8'h85);
        repeat (3) q.push_back(8'h00);
        q.push_back(8'(n >> 8));
        q.push_back(8'(n));
      end
      2, 3, 4: begin
        q.push_back(8'h82);
        q.push_back(8'(n >> 8));
        q.push_back(8'(n));
      end
      5, 6, 7: begin
        q.push_back(8'h81);
        q.push_back(8'(n));
      end
      default: begin
        if (n < 128) q.push_back(8'(n));
        else begin
          q.push_back(8'h82);
          q.push_back(8'(n >> 8));
          q.push_back(8'(n));
        end
      end
    endcase
    foreach (body[i]) q.push_back(body[i]);
  endfunction

  task automatic random_phase(int n_bytes);
    int sent;
    byte_q_t msg;
    sent = 0;
    while (sent < n_bytes) begin
      msg.delete();
      if ($urandom_range(0, 7) == 0) begin
        // noise
        repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
      end else begin
        repeat (($urandom_range(0, 15) == 0) ? 16 : $urandom_range(1, 3)) gen_item(0, msg);
        // cut short to leave something open at message end
        if ($urandom_range(0, 5) == 0 && msg.size() > 1)
          msg = msg[0:$urandom_range(0, msg.size() - 2)];
      end
      send_msg(msg);
      sent += msg.size();
    end
  endtask

  dir_row_t dir_rows[23];

  initial begin
    dir_rows = '{
      // lone integer, length one, value at its maximum
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b1, '{bts_pkg::TK_HEADER, bts_pkg::TY_INT, 64'd1, 3'd0, 1'b1}},
      '{8'hFF, 1'b0, 1'b1, '{bts_pkg::TK_INT, bts_pkg::TY_INT, 64'd255, 3'd0, 1'b1}},
      // unknown tag, then top level skipped to message end without truncation
      '{8'h07, 1'b0, 1'b1, '{bts_pkg::TK_UNKNOWN, bts_pkg::TY_INT, 64'd7, 3'd0, 1'b1}},
      '{8'h00, 1'b1, 1'b0, '0},
      // sequence of ten with a long-form length
      '{8'h30, 1'b0, 1'b0, '0},
      '{8'h82, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h0A, 1'b0, 1'b1, '{bts_pkg::TK_HEADER, bts_pkg::TY_SEQ, 64'd10, 3'd0, 1'b1}},
      // octet string inside
      '{8'h04, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'hAA, 1'b0, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, '0},
      // oid: first byte gives two arcs
      '{8'h06, 1'b0, 1'b0, '0},
      '{8'h03, 1'b0, 1'b0, '0},
      '{8'h2B, 1'b0, 1'b0, '0},
      '{8'h06, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      // null tag where the level ends inside its header
      '{8'h05, 1'b1, 1'b0, '0},
      // pdu with indefinite length
      '{8'hA0, 1'b0, 1'b0, '0},
      '{8'h80, 1'b1, 1'b0, '0},
      // integer cut off by the end of the message
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h05, 1'b1, 1'b0, '0}
    };
    tag_reg = '{8'd2, 8'd4, 8'd5, 8'd6, 8'd48, 8'd160};
    clear_parse();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) put_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed,
                                   dir_rows[i].tok);
    drain();
    random_phase(25);
    drain();

    // extremes, with integer and octets on the same tag to exercise priority
    write_tags(8'h00, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01);
    random_phase(25);
    drain();

    write_tags(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom));
    random_phase(25);
    drain();

    // defaults again, last stretch with no idling on either side
    write_tags(8'd2, 8'd4, 8'd5, 8'd6, 8'd48, 8'd160);
    idle_on = 1'b0;
    random_phase(25);
    drain();
    repeat (10) @(posedge clk);

    if (n_fail == 0) $display("ber_tlv_stream_parser_tb: clean");
    else $display("ber_tlv_stream_parser_tb: errors");
    $finish;
  end

endmodule
